// File: src/pfa_pkg.sv
// shared types, constants and helpers for the page free list allocator
`default_nettype none

package pfa_pkg;

  // pool geometry
  localparam int POOL_DEPTH = 4096;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);

  // field widths
  localparam int FRAME_BITS = 40;
  localparam int BASE_W     = 40;
  localparam int COUNT_W    = 13;
  localparam int INDEX_W    = 12;
  localparam int STATUS_W   = 2;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 1'b1;

  // result queue sizing
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  // classified request from the front end
  typedef struct packed {
    logic               op;
    logic [INDEX_W-1:0] page_index;
    logic               bad_range;
  } pfa_cmd_t;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [BASE_W-1:0]   granted_frame;
    logic [COUNT_W-1:0]  free_pages;
  } pfa_result_t;

  // result queue fill level seen by the back end
  typedef struct packed {
    logic [OQ_CNT_W-1:0] count;
  } pfa_oq_status_t;

  // page count clipped to the pool depth
  function automatic logic [COUNT_W-1:0] pfa_eff_count(input logic [COUNT_W-1:0] cnt);
    logic [COUNT_W-1:0] lim;
    lim = COUNT_W'(POOL_DEPTH);
    return (cnt > lim) ? lim : cnt;
  endfunction

endpackage

`default_nettype wire

// File: src/pfa_front.sv
// front end: accepts requests, range-checks frees, buffers them for the back end
`default_nettype none

module pfa_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  output logic                              in_full,
  input  wire logic                         in_operation,
  input  wire logic [pfa_pkg::INDEX_W-1:0]  in_page_index,
  input  wire logic [pfa_pkg::COUNT_W-1:0]  eff_count,
  output logic                              cmd_valid,
  output pfa_pkg::pfa_cmd_t                 cmd,
  input  wire logic                         cmd_pop
);
  import pfa_pkg::*;

  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = CQ_PTR_W + 1;

  pfa_cmd_t               cq_mem_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                   push;
  logic                   pop;
  pfa_cmd_t               new_cmd;

  // classify the incoming request
  always_comb begin
    new_cmd.op         = in_operation;
    new_cmd.page_index = in_page_index;
    new_cmd.bad_range  = ({1'b0, in_page_index} >= eff_count);
  end

  assign in_full   = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = cq_mem_r[rd_ptr_r];
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      cq_mem_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

`default_nettype wire

// File: src/pfa_back.sv
// back end: free ring memory, head/tail pointers, free count and result forming
`default_nettype none

module pfa_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  input  wire pfa_pkg::pfa_cmd_t             cmd,
  output logic                               cmd_pop,
  input  wire pfa_pkg::pfa_oq_status_t       oq_status,
  input  wire logic                          refill,
  input  wire logic [pfa_pkg::COUNT_W-1:0]   refill_count,
  input  wire logic [pfa_pkg::COUNT_W-1:0]   eff_count,
  input  wire logic [pfa_pkg::BASE_W-1:0]    frame_base,
  output logic                               res_valid,
  output pfa_pkg::pfa_result_t               res
);
  import pfa_pkg::*;

  // ring storage, no reset: untouched slots are served from the fill count
  logic [INDEX_W-1:0]  ring_mem [POOL_DEPTH];
  logic [INDEX_W-1:0]  rdata_r;

  logic [SLOT_W-1:0]   head_r, head_nxt;
  logic [SLOT_W-1:0]   tail_r, tail_nxt;
  logic [COUNT_W-1:0]  total_r, total_nxt;
  logic [COUNT_W-1:0]  init_left_r, init_left_nxt;

  // result stage
  logic                b_valid_r, b_valid_nxt;
  logic [STATUS_W-1:0] b_status_r, b_status_nxt;
  logic                b_grant_r, b_grant_nxt;
  logic                b_use_mem_r, b_use_mem_nxt;
  logic [INDEX_W-1:0]  b_index_r, b_index_nxt;
  logic [COUNT_W-1:0]  b_free_r, b_free_nxt;

  logic                mem_re;
  logic                mem_we;
  logic [OQ_CNT_W:0]   oq_used;
  logic                issue;
  logic [INDEX_W-1:0]  g_index;

  // only issue when the result queue is sure to have room
  assign oq_used = {1'b0, oq_status.count} + (OQ_CNT_W+1)'(b_valid_r);
  assign issue   = cmd_valid && (oq_used < (OQ_CNT_W+1)'(OQ_DEPTH));
  assign cmd_pop = issue;

  // issue stage: refill, checks, pointer and count updates, ring access
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    total_nxt     = total_r;
    init_left_nxt = init_left_r;
    b_valid_nxt   = issue;
    b_status_nxt  = ST_OK;
    b_grant_nxt   = 1'b0;
    b_use_mem_nxt = 1'b0;
    b_index_nxt   = '0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    if (refill) begin
      head_nxt      = '0;
      tail_nxt      = (refill_count >= COUNT_W'(POOL_DEPTH)) ? '0 : refill_count[SLOT_W-1:0];
      total_nxt     = refill_count;
      init_left_nxt = refill_count;
    end else if (issue) begin
      if (cmd.op == OP_ALLOC) begin
        if (total_r == '0) begin
          b_status_nxt = ST_EMPTY;
        end else begin
          b_grant_nxt = 1'b1;
          // slots not rewritten since refill still hold their own number
          if (init_left_r != '0) begin
            b_index_nxt   = INDEX_W'(head_r);
            init_left_nxt = init_left_r - 1'b1;
          end else begin
            b_use_mem_nxt = 1'b1;
            mem_re        = 1'b1;
          end
          head_nxt  = (head_r == SLOT_W'(POOL_DEPTH - 1)) ? '0 : head_r + 1'b1;
          total_nxt = total_r - 1'b1;
        end
      end else begin
        if (cmd.bad_range) begin
          b_status_nxt = ST_RANGE;
        end else if (total_r >= eff_count) begin
          b_status_nxt = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          tail_nxt  = (tail_r == SLOT_W'(POOL_DEPTH - 1)) ? '0 : tail_r + 1'b1;
          total_nxt = total_r + 1'b1;
        end
      end
    end
    b_free_nxt = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      total_r     <= '0;
      init_left_r <= '0;
      b_valid_r   <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      total_r     <= total_nxt;
      init_left_r <= init_left_nxt;
      b_valid_r   <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_status_r  <= b_status_nxt;
    b_grant_r   <= b_grant_nxt;
    b_use_mem_r <= b_use_mem_nxt;
    b_index_r   <= b_index_nxt;
    b_free_r    <= b_free_nxt;
  end

  // ring memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[tail_r] <= cmd.page_index;
    end
  end

  // ring memory registered read port
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= ring_mem[head_r];
    end
  end

  // result stage: pick the index and form the frame number
  assign g_index   = b_use_mem_r ? rdata_r : b_index_r;
  assign res_valid = b_valid_r;

  always_comb begin
    res.status        = b_status_r;
    res.granted_index = b_grant_r ? g_index : '0;
    res.granted_frame = b_grant_r ? BASE_W'(FRAME_BITS'(frame_base + BASE_W'(g_index))) : '0;
    res.free_pages    = b_free_r;
  end

endmodule

`default_nettype wire

// File: src/pfa_out_queue.sv
// result queue between the back end and the result ports
`default_nettype none

module pfa_out_queue (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    wr_en,
  input  wire pfa_pkg::pfa_result_t    wr_data,
  input  wire logic                    out_pop,
  output logic                         out_empty,
  output pfa_pkg::pfa_result_t         rd_data,
  output pfa_pkg::pfa_oq_status_t      oq_status
);
  import pfa_pkg::*;

  pfa_result_t          oq_mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                 pop;

  assign out_empty       = (cnt_r == '0);
  assign rd_data         = oq_mem_r[rd_ptr_r];
  assign oq_status.count = cnt_r;
  assign pop             = out_pop && !out_empty;

  // pointers and fill count; writer never overfills thanks to its credit check
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr_en && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      oq_mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// File: src/page_free_list_allocator_core.sv
// top level of the page free list allocator: config registers and block wiring
//
//  channel   direction  handshake          payload
//  in_       request    in_push / in_full   in_operation, in_page_index
//  out_      result     out_pop / out_empty out_status, out_granted_index,
//                                           out_granted_frame, out_free_pages
//  cfg_      write      cfg_we              cfg_index, cfg_wdata
//
// one request per cycle sustained while results are popped; a result passes
// the request queue, the back end's result register (which also holds the ring
// memory's registered read; the frame adder follows it) and the result queue.
// reset leaves an empty pool with no clearing pass: slots not written since the
// last refill are served from a fill count.
// a stalled result side fills the result queue, then the request queue, then
// raises in_full; the back end issues only with room for its result.
`default_nettype none

module page_free_list_allocator_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic                            in_operation,
  input  wire logic [pfa_pkg::INDEX_W-1:0]     in_page_index,
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic [pfa_pkg::STATUS_W-1:0]         out_status,
  output logic [pfa_pkg::INDEX_W-1:0]          out_granted_index,
  output logic [pfa_pkg::BASE_W-1:0]           out_granted_frame,
  output logic [pfa_pkg::COUNT_W-1:0]          out_free_pages,
  input  wire logic                            cfg_we,
  input  wire logic [pfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import pfa_pkg::*;

  logic [BASE_W-1:0]   frame_base_r, frame_base_nxt;
  logic [COUNT_W-1:0]  page_count_r, page_count_nxt;
  logic                refill;
  logic [COUNT_W-1:0]  refill_count;
  logic [COUNT_W-1:0]  eff_count;

  logic                cmd_valid;
  pfa_cmd_t            cmd;
  logic                cmd_pop;
  pfa_oq_status_t      oq_status;
  logic                res_valid;
  pfa_result_t         res;
  pfa_result_t         out_res;

  // configuration registers
  always_comb begin
    frame_base_nxt = frame_base_r;
    page_count_nxt = page_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_BASE: frame_base_nxt = cfg_wdata[BASE_W-1:0];
        CFG_PAGE_COUNT: page_count_nxt = cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= '0;
      page_count_r <= '0;
    end else begin
      frame_base_r <= frame_base_nxt;
      page_count_r <= page_count_nxt;
    end
  end

  // refill on every page count write
  assign refill       = cfg_we && (cfg_index == CFG_PAGE_COUNT);
  assign refill_count = pfa_eff_count(cfg_wdata[COUNT_W-1:0]);
  assign eff_count    = pfa_eff_count(page_count_r);

  pfa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_operation  (in_operation),
    .in_page_index (in_page_index),
    .eff_count     (eff_count),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  pfa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop),
    .oq_status    (oq_status),
    .refill       (refill),
    .refill_count (refill_count),
    .eff_count    (eff_count),
    .frame_base   (frame_base_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  pfa_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (res_valid),
    .wr_data   (res),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .rd_data   (out_res),
    .oq_status (oq_status)
  );

  // result ports
  assign out_status        = out_res.status;
  assign out_granted_index = out_res.granted_index;
  assign out_granted_frame = out_res.granted_frame;
  assign out_free_pages    = out_res.free_pages;

endmodule

`default_nettype wire

// File: src/pfa_checker.sv
// port-level checks for the page free list allocator, bound to the top level
`default_nettype none

module pfa_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_full,
  input  wire logic                            out_empty,
  input  wire logic [pfa_pkg::STATUS_W-1:0]    out_status,
  input  wire logic [pfa_pkg::INDEX_W-1:0]     out_granted_index,
  input  wire logic [pfa_pkg::BASE_W-1:0]      out_granted_frame,
  input  wire logic [pfa_pkg::COUNT_W-1:0]     out_free_pages
);
  import pfa_pkg::*;

  // reset drains both queues
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a failed request hands out no page
  a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status != ST_OK)) |->
      ((out_granted_index == '0) && (out_granted_frame == '0)))
    else $error("page granted on a failed request");

  // an empty pool report carries a zero free count
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_status == ST_EMPTY)) |-> (out_free_pages == '0))
    else $error("empty pool reported with free pages left");

  // free count never exceeds the pool
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_free_pages <= COUNT_W'(POOL_DEPTH)))
    else $error("free page count above pool depth");

endmodule

bind page_free_list_allocator_core pfa_checker u_pfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_status        (out_status),
  .out_granted_index (out_granted_index),
  .out_granted_frame (out_granted_frame),
  .out_free_pages    (out_free_pages)
);

`default_nettype wire

// File: test/page_free_list_allocator_core_test.sv
// testbench for the page free list allocator core: directed and random requests, scoreboard
`timescale 1ns / 1ps

import pfa_pkg::*;

// free list predictor and store of expected results
class free_list_scoreboard;
  logic [INDEX_W-1:0] ring [POOL_DEPTH];
  logic [SLOT_W-1:0]  head_ptr;
  logic [SLOT_W-1:0]  tail_ptr;
  logic [COUNT_W-1:0] pages_free;
  logic [BASE_W-1:0]  frame_base;
  logic [COUNT_W-1:0] page_count;
  pfa_result_t        pending_results[$];
  logic [INDEX_W-1:0] held_pages[$];
  int                 errors;
  int                 requests_taken;
  int                 results_seen;
  int                 grants;
  int                 returns;
  int                 answers[4];
  int                 pool_settings;

  function new();
    frame_base     = '0;
    page_count     = '0;
    errors         = 0;
    requests_taken = 0;
    results_seen   = 0;
    grants         = 0;
    returns        = 0;
    pool_settings  = 0;
    foreach (answers[i]) answers[i] = 0;
    refill();
  endfunction

  // page count clipped at the ring depth
  function logic [COUNT_W-1:0] pool_size();
    return (page_count > COUNT_W'(POOL_DEPTH)) ? COUNT_W'(POOL_DEPTH) : page_count;
  endfunction

  // ring back to 0..n-1 in order, every page free
  function void refill();
    logic [COUNT_W-1:0] n;
    n = pool_size();
    for (int i = 0; i < POOL_DEPTH; i++) ring[i] = INDEX_W'(i);
    head_ptr   = '0;
    tail_ptr   = (n >= COUNT_W'(POOL_DEPTH)) ? '0 : SLOT_W'(n);
    pages_free = n;
    held_pages.delete();
  endfunction

  function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_FRAME_BASE: frame_base = data[BASE_W-1:0];
      CFG_PAGE_COUNT: begin
        page_count = data[COUNT_W-1:0];
        refill();
      end
      default: ;
    endcase
  endfunction

  // advance the free list by one request and queue the answer it must give
  function void take_request(input logic op, input logic [INDEX_W-1:0] idx);
    pfa_result_t        want;
    logic [COUNT_W-1:0] n;
    n = pool_size();
    want = '0;
    want.status = ST_OK;
    requests_taken++;
    if (op == OP_ALLOC) begin
      if (pages_free == 0) begin
        want.status = ST_EMPTY;
      end else begin
        // slot pointers wrap at the ring depth on their own
        want.granted_index = ring[head_ptr];
        want.granted_frame = frame_base + BASE_W'(ring[head_ptr]);
        head_ptr   = head_ptr + 1'b1;
        pages_free = pages_free - 1'b1;
        held_pages.push_back(want.granted_index);
        grants++;
      end
    end else if (COUNT_W'(idx) >= n) begin
      // range check comes ahead of the full check
      want.status = ST_RANGE;
    end else if (pages_free >= n) begin
      want.status = ST_FULL;
    end else begin
      // a double free goes in again unnoticed
      ring[tail_ptr] = idx;
      tail_ptr   = tail_ptr + 1'b1;
      pages_free = pages_free + 1'b1;
      returns++;
      foreach (held_pages[k]) begin
        if (held_pages[k] == idx) begin
          held_pages.delete(k);
          break;
        end
      end
    end
    want.free_pages = pages_free;
    answers[want.status]++;
    pending_results.push_back(want);
  endfunction

  task report_mismatch(input string what, input longint unsigned got,
                       input longint unsigned want);
    errors++;
    if (errors <= 40)
      $display("mismatch at %0t, result %0d: %s got 0x%0h want 0x%0h",
               $realtime, results_seen, what, got, want);
  endtask

  // compare one popped result with the oldest expectation
  task match_result(input pfa_result_t got);
    pfa_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no request waiting, status", got.status, 0);
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", got.status, want.status);
      if (got.granted_index !== want.granted_index)
        report_mismatch("granted_index", got.granted_index, want.granted_index);
      if (got.granted_frame !== want.granted_frame)
        report_mismatch("granted_frame", got.granted_frame, want.granted_frame);
      if (got.free_pages !== want.free_pages)
        report_mismatch("free_pages", got.free_pages, want.free_pages);
    end
  endtask
endclass

module page_free_list_allocator_core_test;
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  in_push       = 1'b0;
  logic                  in_operation  = OP_ALLOC;
  logic [INDEX_W-1:0]    in_page_index = '0;
  logic                  out_pop       = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = CFG_FRAME_BASE;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  in_full;
  logic                  out_empty;
  logic [STATUS_W-1:0]   out_status;
  logic [INDEX_W-1:0]    out_granted_index;
  logic [BASE_W-1:0]     out_granted_frame;
  logic [COUNT_W-1:0]    out_free_pages;

  int send_gap_pct  = 0;
  int pop_stall_pct = 0;
  int cycle_count   = 0;

  free_list_scoreboard sb;

  page_free_list_allocator_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_operation      (in_operation),
    .in_page_index     (in_page_index),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_granted_frame (out_granted_frame),
    .out_free_pages    (out_free_pages),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random pop stalls, check on every accepted result
  initial begin
    pfa_result_t seen;
    forever begin
      @(negedge clk);
      out_pop <= rst_n && ($urandom_range(99) >= pop_stall_pct);
      @(posedge clk);
      if (out_pop && !out_empty) begin
        seen.status        = out_status;
        seen.granted_index = out_granted_index;
        seen.granted_frame = out_granted_frame;
        seen.free_pages    = out_free_pages;
        sb.match_result(seen);
      end
    end
  end

  // one request, with a random gap ahead of it; returns at a falling edge
  task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx);
    logic taken;
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push       <= 1'b1;
    in_operation  <= op;
    in_page_index <= idx;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!in_full) begin
        taken = 1'b1;
        sb.take_request(op, idx);
      end
      @(negedge clk);
    end
  endtask

  // drain all results, then let the pipeline settle
  task automatic wait_idle();
    in_push <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write both registers back to back while idle
  task automatic set_pool(input logic [BASE_W-1:0] base, input logic [COUNT_W-1:0] count);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FRAME_BASE;
    cfg_wdata <= CFG_DATA_W'(base);
    @(posedge clk);
    sb.write_reg(CFG_FRAME_BASE, CFG_DATA_W'(base));
    @(negedge clk);
    cfg_index <= CFG_PAGE_COUNT;
    cfg_wdata <= CFG_DATA_W'(count);
    @(posedge clk);
    sb.write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(count));
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.pool_settings++;
  endtask

  // random traffic on one pool: bursts lean to allocate, to free, or neither;
  // most frees hand back a page that is out, the rest are doubles or noise
  task automatic run_pool(input logic [BASE_W-1:0] base, input logic [COUNT_W-1:0] count,
                          input int n_requests);
    int                 alloc_pct;
    int                 pick;
    logic               op;
    logic [INDEX_W-1:0] idx;
    logic [COUNT_W-1:0] size;
    alloc_pct = 50;
    set_pool(base, count);
    for (int k = 0; k < n_requests; k++) begin
      if (k % 16 == 0) begin
        case ($urandom_range(2))
          0:       alloc_pct = 80;
          1:       alloc_pct = 20;
          default: alloc_pct = 50;
        endcase
      end
      op   = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
      idx  = INDEX_W'($urandom_range(POOL_DEPTH - 1));
      size = sb.pool_size();
      pick = $urandom_range(99);
      if (op == OP_FREE) begin
        if (pick < 70 && sb.held_pages.size() != 0)
          idx = sb.held_pages[$urandom_range(sb.held_pages.size() - 1)];
        else if (pick < 85 && size != 0)
          idx = INDEX_W'($urandom_range(size - 1));
      end
      send_request(op, idx);
    end
  endtask

  // stimulus
  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty pool straight out of reset
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '0);
    send_request(OP_FREE, '1);

    // three pages near the top of the frame space: wrap, empty, double free,
    // full list, out of range
    set_pool(40'hFF_FFFF_FFFE, 13'd3);
    repeat (4) send_request(OP_ALLOC, '1);
    send_request(OP_FREE, 12'd2);
    send_request(OP_FREE, 12'd2);
    send_request(OP_FREE, 12'd0);
    send_request(OP_FREE, 12'd1);
    send_request(OP_FREE, 12'd3);
    send_request(OP_FREE, '1);
    repeat (3) send_request(OP_ALLOC, '0);

    // oversized count clips to the ring depth
    set_pool('0, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, '1);
    send_request(OP_FREE, '1);
    send_request(OP_ALLOC, '0);

    // full ring, largest base
    set_pool('1, COUNT_W'(POOL_DEPTH));
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);

    // sender gaps light, receiver stalls heavy
    send_gap_pct  = 29;
    pop_stall_pct = 57;
    run_pool(BASE_W'({$urandom, $urandom}), 13'd8, 110);
    run_pool(40'hFF_FFFF_FFF0, 13'd16, 110);

    // sender gaps heavy, receiver stalls light
    send_gap_pct  = 57;
    pop_stall_pct = 29;
    run_pool(BASE_W'({$urandom, $urandom}), COUNT_W'(POOL_DEPTH), 110);
    run_pool(BASE_W'({$urandom, $urandom}), 13'd1, 50);
    run_pool(BASE_W'({$urandom, $urandom}),
             COUNT_W'($urandom_range(8191, POOL_DEPTH + 1)), 80);

    // back to back both ways
    send_gap_pct  = 0;
    pop_stall_pct = 0;
    run_pool(BASE_W'({$urandom, $urandom}), 13'd37, 130);
    run_pool('1, 13'd2, 60);
    run_pool(BASE_W'({$urandom, $urandom}), '0, 30);

    wait_idle();
    $display("%0d requests over %0d pool settings, %0d results checked",
             sb.requests_taken, sb.pool_settings, sb.results_seen);
    $display("pages granted %0d, returned %0d; empty %0d, full %0d, out of range %0d",
             sb.grants, sb.returns, sb.answers[ST_EMPTY], sb.answers[ST_FULL],
             sb.answers[ST_RANGE]);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
